FILE: rtl/sges_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sges_pkg
// Shared codes, port widths and controller/datapath bundles for the graph
// edge store.
// ----------------------------------------------------------------------------
package sges_pkg;

  // fixed widths of the word fields
  localparam int OP_W     = 3;
  localparam int NODE_W   = 6;
  localparam int COST_W   = 16;
  localparam int NCNT_W   = 7;
  localparam int ECNT_W   = 13;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_DIRECTED = 1'b0;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD_NODE  = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_EDGE  = 3'd2;
  localparam logic [OP_W-1:0] OP_GET_EDGE  = 3'd3;
  localparam logic [OP_W-1:0] OP_NODE_PRES = 3'd4;
  localparam logic [OP_W-1:0] OP_EDGE_PRES = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd6;

  // result status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // word taken: latch fields, run the ops that need no row read
    logic rd_a;       // read row of node a (and weight a,b)
    logic rd_b;       // read row of node b
    logic put_ab;     // set edge a->b unless present
    logic put_ba;     // set edge b->a unless present
    logic get_done;   // resolve get edge
    logic pres_done;  // resolve edge present
    logic rm_start;   // capture row a, reset walk counter
    logic walk;       // one step of the row/column erase walk
    logic load_out;   // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic live_a;
    logic live_b;
    logic walk_end;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/sparse_graph_edge_store_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_graph_edge_store_unit
// Graph adjacency store: node valid bits, an edge bit matrix with a cost per
// edge, running node and edge counts.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i/in_ready_o) takes one command word: operation,
//   node_a, node_b, cost. Output channel (out_valid_o/out_ready_i) returns
//   exactly one result word per command: status, edge_cost, node count and
//   edge count after the command.
//   One command is in flight at a time. Steps from acceptance to the result
//   sitting in the output register:
//     add node, remove of a dead node, node present, clear, bad add edge : response
//     get edge, edge present, directed add edge : row a read, response
//     undirected add edge : row a read, row b read for the mirror, response
//     remove node : row a read, erase walk, response (the walk visits every matrix row
//                   through the single read and write port of the row RAM)
//   The next command is taken the cycle after the result is loaded, so a
//   result may wait in the output register while the next command runs; if
//   the receiver still stalls when that one finishes, the block holds it.
//   Reset (rst_ni low, asynchronous) empties the graph: no nodes, no edges,
//   directed_mode 0. No clearing pass is needed; row valid flags mask stale
//   matrix rows. Edge costs are not reset and are only read for edges that
//   exist.
//   Config: directed_mode at byte address 0 (bit 0), APB write, pready high.
// ----------------------------------------------------------------------------
module sparse_graph_edge_store_unit #(
  parameter int MAX_NODES = 64,
  parameter int COST_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command words
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sges_pkg::OP_W-1:0]         operation_i,
  input  logic [sges_pkg::NODE_W-1:0]       node_a_i,
  input  logic [sges_pkg::NODE_W-1:0]       node_b_i,
  input  logic [sges_pkg::COST_W-1:0]       cost_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              status_o,
  output logic [sges_pkg::COST_W-1:0]       edge_cost_o,
  output logic [sges_pkg::NCNT_W-1:0]       next_node_index_o,
  output logic [sges_pkg::ECNT_W-1:0]       edge_count_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sges_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sges_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sges_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import sges_pkg::*;

  logic  directed_q;
  logic  reg_sel;
  cmd_t  cmd;
  stat_t stat;

  // register index is the word address
  assign reg_sel = (paddr[2:2] == REG_DIRECTED);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CFG_DATA_W'(directed_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      directed_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      directed_q <= pwdata[0];
    end
  end

  sges_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .directed_i  (directed_q),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sges_dp #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .operation_i       (operation_i),
    .node_a_i          (node_a_i),
    .node_b_i          (node_b_i),
    .cost_i            (cost_i),
    .status_o          (status_o),
    .edge_cost_o       (edge_cost_o),
    .next_node_index_o (next_node_index_o),
    .edge_count_o      (edge_count_o)
  );

endmodule
`default_nettype wire

FILE: rtl/sges_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sges_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sges_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sges_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sges_ctrl
// Sequencer: input/output handshake and the command stream for the datapath.
// ----------------------------------------------------------------------------
module sges_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sges_pkg::OP_W-1:0] operation_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  logic                      directed_i,
  input  sges_pkg::stat_t           stat_i,
  output sges_pkg::cmd_t            cmd_o
);
  import sges_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROWA = 3'd1;  // row a read data valid
  localparam logic [2:0] S_RDB  = 3'd2;  // issue read of row b
  localparam logic [2:0] S_ROWB = 3'd3;  // row b read data valid
  localparam logic [2:0] S_WALK = 3'd4;  // erase walk over all rows
  localparam logic [2:0] S_RESP = 3'd5;  // hand result to output register

  logic [2:0]      state_q, state_d;
  logic            out_vld_q, out_vld_d;
  logic [OP_W-1:0] op_q;
  logic            take;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign take        = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    out_vld_d = out_vld_q;
    cmd_o     = '0;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RESP;
          case (operation_i) inside
            OP_REMOVE: begin
              if (stat_i.live_a) begin
                cmd_o.rd_a = 1'b1;
                state_d    = S_ROWA;
              end
            end
            OP_ADD_EDGE: begin
              if (stat_i.live_a && stat_i.live_b) begin
                cmd_o.rd_a = 1'b1;
                state_d    = S_ROWA;
              end
            end
            OP_GET_EDGE, OP_EDGE_PRES: begin
              cmd_o.rd_a = 1'b1;
              state_d    = S_ROWA;
            end
            default: ;
          endcase
        end
      end
      S_ROWA: begin
        state_d = S_RESP;
        case (op_q)
          OP_GET_EDGE:  cmd_o.get_done  = 1'b1;
          OP_EDGE_PRES: cmd_o.pres_done = 1'b1;
          OP_ADD_EDGE: begin
            cmd_o.put_ab = 1'b1;
            if (!directed_i) begin
              state_d = S_RDB;
            end
          end
          OP_REMOVE: begin
            cmd_o.rm_start = 1'b1;
            state_d        = S_WALK;
          end
          default: ;
        endcase
      end
      S_RDB: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_ROWB;
      end
      S_ROWB: begin
        cmd_o.put_ba = 1'b1;
        state_d      = S_RESP;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_end) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_vld_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q <= operation_i;
    end
  end

  // result register is never overwritten while still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_vld_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_resp_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && !out_vld_q) |=> state_q == S_IDLE)
    else $error("response stalled with free output register");

  a_simple_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && operation_i == OP_NODE_PRES) |=> state_q == S_RESP)
    else $error("node present did not go straight to response");

  a_walk_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && !stat_i.walk_end) |=> state_q == S_WALK)
    else $error("erase walk left early");

endmodule
`default_nettype wire

FILE: rtl/sges_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sges_dp
// Datapath: node valid bits, counters, edge bit matrix and cost memories,
// result and output registers.
// ----------------------------------------------------------------------------
module sges_dp #(
  parameter int MAX_NODES = 64,
  parameter int COST_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sges_pkg::cmd_t                cmd_i,
  output sges_pkg::stat_t               stat_o,
  input  logic [sges_pkg::OP_W-1:0]     operation_i,
  input  logic [sges_pkg::NODE_W-1:0]   node_a_i,
  input  logic [sges_pkg::NODE_W-1:0]   node_b_i,
  input  logic [sges_pkg::COST_W-1:0]   cost_i,
  output logic                          status_o,
  output logic [sges_pkg::COST_W-1:0]   edge_cost_o,
  output logic [sges_pkg::NCNT_W-1:0]   next_node_index_o,
  output logic [sges_pkg::ECNT_W-1:0]   edge_count_o
);
  import sges_pkg::*;

  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int EDGE_W  = $clog2(MAX_NODES * MAX_NODES + 1);
  localparam int WADDR_W = 2 * IDX_W;
  localparam int WDEPTH  = 1 << WADDR_W;
  localparam logic [MAX_NODES-1:0] ROW_ONE = MAX_NODES'(1);

  // state
  logic [MAX_NODES-1:0] node_valid_q, node_valid_d;
  logic [CNT_W-1:0]     node_cnt_q, node_cnt_d;
  logic [EDGE_W-1:0]    edge_cnt_q, edge_cnt_d;
  logic [MAX_NODES-1:0] row_vld_q, row_vld_d;
  logic                 rd_vld_q;

  // latched word and working registers
  logic [IDX_W-1:0]     a_idx_q, b_idx_q;
  logic [COST_BITS-1:0] cost_q;
  logic                 inr_ab_q, live_ab_q;
  logic                 res_status_q, res_status_d;
  logic [COST_BITS-1:0] res_cost_q, res_cost_d;
  logic [MAX_NODES-1:0] rowa_sh_q, rowa_sh_d;
  logic [CNT_W-1:0]     walk_cnt_q, walk_cnt_d;

  // port-side decode
  logic [IDX_W-1:0]     a_idx, b_idx;
  logic                 a_inr, b_inr, a_live, b_live;

  // memory ports
  logic                 row_re, row_we;
  logic [IDX_W-1:0]     row_raddr, row_waddr;
  logic [MAX_NODES-1:0] row_wdata, row_rdata, eff_row;
  logic                 w_re, w_we;
  logic [WADDR_W-1:0]   w_raddr, w_waddr;
  logic [COST_BITS-1:0] w_rdata;

  // walk
  logic [IDX_W-1:0]     wk_idx;
  logic                 wk_rd, wk_pend, wk_self, col_hit, walk_end;
  logic                 hit_ab, hit_ba, add_ab, add_ba;
  logic [EDGE_W-1:0]    drop_n;

  assign a_idx  = IDX_W'(node_a_i);
  assign b_idx  = IDX_W'(node_b_i);
  assign a_inr  = 32'(node_a_i) < 32'(MAX_NODES);
  assign b_inr  = 32'(node_b_i) < 32'(MAX_NODES);
  assign a_live = a_inr && (32'(node_a_i) < 32'(node_cnt_q)) && node_valid_q[a_idx];
  assign b_live = b_inr && (32'(node_b_i) < 32'(node_cnt_q)) && node_valid_q[b_idx];

  // a row never written since reset or clear reads as empty
  assign eff_row = rd_vld_q ? row_rdata : '0;
  assign hit_ab  = eff_row[b_idx_q];
  assign hit_ba  = eff_row[a_idx_q];
  assign add_ab  = cmd_i.put_ab && !hit_ab;
  assign add_ba  = cmd_i.put_ba && !hit_ba;

  // walk step k reads row k and writes back row k-1
  assign walk_end = (walk_cnt_q == CNT_W'(MAX_NODES));
  assign wk_rd    = cmd_i.walk && !walk_end;
  assign wk_pend  = cmd_i.walk && (walk_cnt_q != '0);
  assign wk_idx   = IDX_W'(walk_cnt_q - CNT_W'(1));
  assign wk_self  = (wk_idx == a_idx_q);
  assign col_hit  = eff_row[a_idx_q] && !wk_self;
  assign drop_n   = EDGE_W'(rowa_sh_q[0]) + EDGE_W'(col_hit);

  assign stat_o.live_a   = a_live;
  assign stat_o.live_b   = b_live;
  assign stat_o.walk_end = walk_end;

  always_comb begin
    row_re    = 1'b0;
    row_raddr = a_idx;
    w_re      = 1'b0;
    w_raddr   = {a_idx, b_idx};
    row_we    = 1'b0;
    row_waddr = a_idx_q;
    row_wdata = eff_row | (ROW_ONE << b_idx_q);
    w_we      = 1'b0;
    w_waddr   = {a_idx_q, b_idx_q};
    if (cmd_i.rd_a) begin
      row_re = 1'b1;
      w_re   = 1'b1;
    end
    if (cmd_i.rd_b) begin
      row_re    = 1'b1;
      row_raddr = b_idx_q;
    end
    if (wk_rd) begin
      row_re    = 1'b1;
      row_raddr = IDX_W'(walk_cnt_q);
    end
    if (add_ab) begin
      row_we = 1'b1;
      w_we   = 1'b1;
    end
    if (add_ba) begin
      row_we    = 1'b1;
      w_we      = 1'b1;
      row_waddr = b_idx_q;
      row_wdata = eff_row | (ROW_ONE << a_idx_q);
      w_waddr   = {b_idx_q, a_idx_q};
    end
    if (wk_pend) begin
      row_we    = 1'b1;
      row_waddr = wk_idx;
      row_wdata = wk_self ? '0 : (eff_row & ~(ROW_ONE << a_idx_q));
    end
  end

  always_comb begin
    node_valid_d = node_valid_q;
    node_cnt_d   = node_cnt_q;
    edge_cnt_d   = edge_cnt_q;
    row_vld_d    = row_vld_q;
    res_status_d = res_status_q;
    res_cost_d   = res_cost_q;
    rowa_sh_d    = rowa_sh_q;
    walk_cnt_d   = walk_cnt_q;

    if (cmd_i.accept) begin
      res_cost_d = '0;
      case (operation_i)
        OP_ADD_NODE: begin
          res_status_d = STAT_FAIL;
          if (a_inr && (32'(node_a_i) < 32'(node_cnt_q))) begin
            node_valid_d[a_idx] = 1'b1;
            res_status_d        = STAT_OK;
          end else if (32'(node_cnt_q) < 32'(MAX_NODES)) begin
            node_valid_d[IDX_W'(node_cnt_q)] = 1'b1;
            node_cnt_d   = node_cnt_q + CNT_W'(1);
            res_status_d = STAT_OK;
          end
        end
        OP_REMOVE: begin
          res_status_d = a_live ? STAT_OK : STAT_FAIL;
          if (a_live) begin
            node_valid_d[a_idx] = 1'b0;
          end
        end
        OP_ADD_EDGE:  res_status_d = (a_live && b_live) ? STAT_OK : STAT_FAIL;
        OP_NODE_PRES: res_status_d = a_live ? STAT_OK : STAT_FAIL;
        OP_CLEAR: begin
          node_valid_d = '0;
          node_cnt_d   = '0;
          edge_cnt_d   = '0;
          row_vld_d    = '0;
          res_status_d = STAT_OK;
        end
        default: res_status_d = STAT_FAIL;
      endcase
    end

    if (row_we) begin
      row_vld_d[row_waddr] = 1'b1;
    end

    if (cmd_i.get_done) begin
      res_status_d = (inr_ab_q && hit_ab) ? STAT_OK : STAT_FAIL;
      res_cost_d   = (inr_ab_q && hit_ab) ? w_rdata : '0;
    end
    if (cmd_i.pres_done) begin
      res_status_d = (live_ab_q && hit_ab) ? STAT_OK : STAT_FAIL;
    end

    if (add_ab || add_ba) begin
      edge_cnt_d = edge_cnt_q + EDGE_W'(1);
    end

    if (cmd_i.rm_start) begin
      rowa_sh_d  = eff_row;
      walk_cnt_d = '0;
    end
    if (wk_rd) begin
      walk_cnt_d = walk_cnt_q + CNT_W'(1);
    end
    if (wk_pend) begin
      rowa_sh_d  = rowa_sh_q >> 1;
      edge_cnt_d = edge_cnt_q - drop_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_valid_q <= '0;
      node_cnt_q   <= '0;
      edge_cnt_q   <= '0;
      row_vld_q    <= '0;
      rd_vld_q     <= 1'b0;
      walk_cnt_q   <= '0;
    end else begin
      node_valid_q <= node_valid_d;
      node_cnt_q   <= node_cnt_d;
      edge_cnt_q   <= edge_cnt_d;
      row_vld_q    <= row_vld_d;
      walk_cnt_q   <= walk_cnt_d;
      if (row_re) begin
        rd_vld_q <= row_vld_q[row_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_cost_q   <= res_cost_d;
    rowa_sh_q    <= rowa_sh_d;
    if (cmd_i.accept) begin
      a_idx_q   <= a_idx;
      b_idx_q   <= b_idx;
      cost_q    <= COST_BITS'(cost_i);
      inr_ab_q  <= a_inr && b_inr;
      live_ab_q <= a_live && b_live;
    end
    if (cmd_i.load_out) begin
      status_o          <= res_status_q;
      edge_cost_o       <= COST_W'(res_cost_q);
      next_node_index_o <= NCNT_W'(node_cnt_q);
      edge_count_o      <= ECNT_W'(edge_cnt_q);
    end
  end

  // edge bit matrix, one row per source node
  sges_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  // edge costs, addressed {source, destination}
  sges_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (WDEPTH)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (cost_q),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  a_nodes_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (node_valid_q >> node_cnt_q) == '0)
    else $error("valid node at or above node count");

  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edge_cnt_q) <= 32'(MAX_NODES * MAX_NODES))
    else $error("edge count beyond matrix size");

  a_put_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_ab |=> edge_cnt_q == $past(edge_cnt_q) + EDGE_W'(1))
    else $error("new edge not counted");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the graph edge store. An initial block queues
// command words (a directed opening, then random traffic in runs of node
// additions and edge work mostly on existing slots) and changes the directed
// mode between phases. A clocked driver offers the words and, on each accepted
// word, moves a private copy of the graph forward to work out the result word
// that is due. A clocked monitor checks every field of each result in order.
// ----------------------------------------------------------------------------
module tb;
  import sges_pkg::*;

  localparam int GRAPH_NODES = 64;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;  // no operation on this code

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [COST_W-1:0] cost;
  } graph_cmd_t;

  typedef struct packed {
    logic              status;
    logic [COST_W-1:0] edge_cost;
    logic [NCNT_W-1:0] node_total;
    logic [ECNT_W-1:0] edge_total;
  } graph_res_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // block ports
  logic                  in_valid  = 1'b0;
  logic                  in_ready_o;
  graph_cmd_t            cur_cmd   = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  logic                  status_o;
  logic [COST_W-1:0]     edge_cost_o;
  logic [NCNT_W-1:0]     next_node_index_o;
  logic [ECNT_W-1:0]     edge_count_o;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  sparse_graph_edge_store_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .operation_i       (cur_cmd.op),
    .node_a_i          (cur_cmd.node_a),
    .node_b_i          (cur_cmd.node_b),
    .cost_i            (cur_cmd.cost),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .status_o          (status_o),
    .edge_cost_o       (edge_cost_o),
    .next_node_index_o (next_node_index_o),
    .edge_count_o      (edge_count_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // --------------------------------------------------------------------------
  // Shadow graph: node flags, edge matrix, costs and the two running counts.
  // Costs are only ever read where the matrix bit is set.
  // --------------------------------------------------------------------------
  logic                    directed_cfg = 1'b0;
  logic                    node_live [GRAPH_NODES];
  logic [GRAPH_NODES-1:0]  adj_row   [GRAPH_NODES];
  logic [COST_W-1:0]       cost_mem  [GRAPH_NODES][GRAPH_NODES];
  logic [NCNT_W-1:0]       node_total = '0;
  logic [ECNT_W-1:0]       edge_total = '0;

  graph_cmd_t cmd_pend [$];   // words waiting for the driver
  graph_res_t res_due  [$];   // result words owed by the block, oldest first

  int faults      = 0;
  int words_in    = 0;
  int words_out   = 0;
  int queued      = 0;
  int gen_nodes   = 0;        // node count as the queued stream will leave it
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  initial begin
    for (int i = 0; i < GRAPH_NODES; i++) begin
      node_live[i] = 1'b0;
      adj_row[i]   = '0;
    end
  end

  function automatic bit node_alive(input logic [NODE_W-1:0] n);
    return ({1'b0, n} < node_total) && node_live[n];
  endfunction

  function automatic void link_edge(input logic [NODE_W-1:0] f, input logic [NODE_W-1:0] t,
                                    input logic [COST_W-1:0] c);
    if (!adj_row[f][t]) begin
      adj_row[f][t] = 1'b1;
      cost_mem[f][t] = c;
      edge_total++;
    end
  endfunction

  function automatic void unlink_edge(input logic [NODE_W-1:0] f, input logic [NODE_W-1:0] t);
    if (adj_row[f][t]) begin
      adj_row[f][t] = 1'b0;
      edge_total--;
    end
  endfunction

  // apply one accepted word to the shadow graph and queue its result word
  function automatic void apply_graph_cmd(input graph_cmd_t c);
    graph_res_t r;
    r = '0;
    r.status = STAT_FAIL;
    case (c.op)
      OP_ADD_NODE: begin
        if ({1'b0, c.node_a} < node_total) begin
          node_live[c.node_a] = 1'b1;          // revive an existing slot
          r.status = STAT_OK;
        end else if (node_total < GRAPH_NODES) begin
          node_live[node_total[NODE_W-1:0]] = 1'b1;
          node_total++;
          r.status = STAT_OK;
        end
      end
      OP_REMOVE: begin
        if (node_alive(c.node_a)) begin
          node_live[c.node_a] = 1'b0;
          for (int i = 0; i < GRAPH_NODES; i++) begin
            unlink_edge(c.node_a, NODE_W'(i));
            unlink_edge(NODE_W'(i), c.node_a);
          end
          r.status = STAT_OK;
        end
      end
      OP_ADD_EDGE: begin
        if (node_alive(c.node_a) && node_alive(c.node_b)) begin
          link_edge(c.node_a, c.node_b, c.cost);
          if (!directed_cfg) link_edge(c.node_b, c.node_a, c.cost);
          r.status = STAT_OK;
        end
      end
      OP_GET_EDGE: begin
        if (adj_row[c.node_a][c.node_b]) begin
          r.edge_cost = cost_mem[c.node_a][c.node_b];
          r.status = STAT_OK;
        end
      end
      OP_NODE_PRES: r.status = node_alive(c.node_a) ? STAT_OK : STAT_FAIL;
      OP_EDGE_PRES: begin
        if (node_alive(c.node_a) && node_alive(c.node_b) && adj_row[c.node_a][c.node_b])
          r.status = STAT_OK;
      end
      OP_CLEAR: begin
        for (int i = 0; i < GRAPH_NODES; i++) begin
          node_live[i] = 1'b0;
          adj_row[i]   = '0;
        end
        node_total = '0;
        edge_total = '0;
        r.status = STAT_OK;
      end
      default: ;
    endcase
    r.node_total = node_total;
    r.edge_total = edge_total;
    res_due = {res_due, r};
  endfunction

  function automatic void report_fault(input string msg);
    faults++;
    if (faults <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic string show_res(input graph_res_t r);
    return $sformatf("status=%0d cost=0x%04h nodes=%0d edges=%0d",
                     r.status, r.edge_cost, r.node_total, r.edge_total);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued words, keeps valid and payload steady until taken,
  // idles at random except in a calm window of words.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bit waiting;
    bit calm;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cur_cmd  <= '0;
    end else begin
      waiting = in_valid && !in_ready_o;
      if (in_valid && in_ready_o) begin
        apply_graph_cmd(cur_cmd);
        words_in++;
      end
      calm = (words_in >= 100) && (words_in < 200);
      if (!waiting) begin
        if (cmd_pend.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          cur_cmd  <= cmd_pend.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes result words and checks them against the oldest one due.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    graph_res_t got;
    graph_res_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      words_out <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        got = {status_o, edge_cost_o, next_node_index_o, edge_count_o};
        words_out <= words_out + 1;
        if (res_due.size() == 0) begin
          report_fault({"result word with nothing due: ", show_res(got)});
        end else begin
          want = res_due.pop_front();
          if (got.status !== want.status || got.edge_cost !== want.edge_cost ||
              got.node_total !== want.node_total || got.edge_total !== want.edge_total)
            report_fault({"word ", $sformatf("%0d", words_out), " exp ", show_res(want),
                          " got ", show_res(got)});
        end
      end
      if (hold_left != 0)
        out_ready <= 1'b0;
        else if (words_out >= 100 && words_out < 200)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 99) >= 25);
    end
  end

  // one long back-pressure stretch, so the block fills and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_out == 300) begin
      hold_left <= 200;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_cmd(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] a,
                                    input logic [NODE_W-1:0] b, input logic [COST_W-1:0] c);
    graph_cmd_t w;
    w = '{op: op, node_a: a, node_b: b, cost: c};
    cmd_pend = {cmd_pend, w};
    queued++;
    if (op == OP_ADD_NODE && int'(a) >= gen_nodes && gen_nodes < GRAPH_NODES) gen_nodes++;
    if (op == OP_CLEAR) gen_nodes = 0;
  endfunction

  // mostly an index of an existing slot, now and then anywhere
  function automatic logic [NODE_W-1:0] pick_node();
    if (gen_nodes == 0 || $urandom_range(0, 99) < 15)
      return NODE_W'($urandom_range(0, GRAPH_NODES - 1));
    return NODE_W'($urandom_range(0, gen_nodes - 1));
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return COST_W'($urandom_range(0, 65535));
  endfunction

  function automatic void queue_random(input int count);
    int target;
    int r;
    int run;
    target = queued + count;
    while (queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // run of node additions; now and then long enough to fill the store
        run = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(1, 12);
        repeat (run) queue_cmd(OP_ADD_NODE, NODE_W'($urandom_range(0, 63)), pick_node(),
                               pick_cost());
      end else if (r < 10) begin
        queue_cmd(OP_CLEAR, pick_node(), pick_node(), pick_cost());
      end else if (r < 20) begin
        // noise: any code, any index
        queue_cmd(OP_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 63)),
                  NODE_W'($urandom_range(0, 63)), COST_W'($urandom_range(0, 65535)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35)      queue_cmd(OP_ADD_EDGE,  pick_node(), pick_node(), pick_cost());
        else if (r < 50) queue_cmd(OP_GET_EDGE,  pick_node(), pick_node(), pick_cost());
        else if (r < 62) queue_cmd(OP_EDGE_PRES, pick_node(), pick_node(), pick_cost());
        else if (r < 72) queue_cmd(OP_NODE_PRES, pick_node(), pick_node(), pick_cost());
        else if (r < 80) queue_cmd(OP_REMOVE,    pick_node(), pick_node(), pick_cost());
        else             queue_cmd(OP_ADD_NODE,  pick_node(), pick_node(), pick_cost());
      end
    end
  endfunction

  // wait until every queued word is taken and answered, plus some slack
  task automatic settle(input int slack);
    do @(negedge clk_i);
    while (cmd_pend.size() != 0 || in_valid || res_due.size() != 0);
    repeat (slack) @(posedge clk_i);
  endtask

  // setup and access cycle; the register takes the value at the access edge
  task automatic write_mode(input logic mode);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DIRECTED, 2'b00};
    pwdata  <= {{(CFG_DATA_W-1){1'b0}}, mode};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    directed_cfg = mode;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Run sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opening, directed mode: empty store, appends, revive, one-way edge
    write_mode(1'b1);
    queue_cmd(OP_NODE_PRES, 6'd0,  6'd0,  16'h0000);   // nothing there yet
    queue_cmd(OP_ADD_EDGE,  6'd0,  6'd0,  16'h0001);   // both ends invalid
    queue_cmd(OP_ADD_NODE,  6'd63, 6'd0,  16'h0000);   // appends slot 0
    queue_cmd(OP_ADD_NODE,  6'd63, 6'd63, 16'hFFFF);   // appends slot 1
    queue_cmd(OP_ADD_NODE,  6'd0,  6'd0,  16'h0000);   // revive of a live slot
    queue_cmd(OP_ADD_EDGE,  6'd0,  6'd1,  16'hFFFF);
    queue_cmd(OP_EDGE_PRES, 6'd1,  6'd0,  16'h0000);   // no mirror in this mode
    queue_cmd(OP_UNUSED,    6'd63, 6'd63, 16'hFFFF);
    settle(4);

    // undirected: duplicate keeps its cost but the mirror is added
    write_mode(1'b0);
    queue_cmd(OP_ADD_EDGE,  6'd0,  6'd1,  16'h0000);
    queue_cmd(OP_GET_EDGE,  6'd0,  6'd1,  16'h0000);
    queue_cmd(OP_GET_EDGE,  6'd1,  6'd0,  16'h0000);
    queue_cmd(OP_ADD_EDGE,  6'd1,  6'd1,  16'h1234);   // self loop
    queue_cmd(OP_GET_EDGE,  6'd1,  6'd1,  16'h0000);
    queue_cmd(OP_EDGE_PRES, 6'd0,  6'd63, 16'h0000);   // end beyond the count
    queue_cmd(OP_NODE_PRES, 6'd63, 6'd0,  16'h0000);
    queue_cmd(OP_GET_EDGE,  6'd63, 6'd63, 16'h0000);
    queue_cmd(OP_REMOVE,    6'd1,  6'd0,  16'h0000);   // drops row and column
    queue_cmd(OP_REMOVE,    6'd1,  6'd0,  16'h0000);   // already dead
    queue_cmd(OP_NODE_PRES, 6'd1,  6'd0,  16'h0000);
    queue_cmd(OP_ADD_EDGE,  6'd0,  6'd1,  16'h4321);   // dead end
    queue_cmd(OP_ADD_NODE,  6'd1,  6'd0,  16'h0000);
    queue_cmd(OP_ADD_EDGE,  6'd1,  6'd0,  16'h8001);
    queue_cmd(OP_CLEAR,     6'd0,  6'd0,  16'h0000);
    queue_cmd(OP_GET_EDGE,  6'd1,  6'd0,  16'h0000);
    queue_random(200);
    settle(4);

    write_mode(1'b1);
    queue_random(200);
    settle(4);

    write_mode(1'b0);
    queue_random(200);

    // longest operation is a node removal walking every row
    settle(GRAPH_NODES + 16);
    if (faults == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
